### design/dtp_pkg.sv
package dtp_pkg;

    localparam int WIN_LEN       = 17;
    localparam int HIST_LEN      = 6;
    localparam int OUT_DEPTH_DEF = 4;

    typedef struct packed {
        logic       mode;
        logic [7:0] character;
    } t_in;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_DATA     = 2'd1,
        ST_ADAPTER_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        t_status    status;
    } t_out;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_FIRST = 2'd1,
        PH_BODY  = 2'd2
    } t_phase;

    typedef struct packed {
        logic shift;
        logic two;
        logic clr;
    } t_cell_ctl;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic MODE_CHAR   = 1'b0;
    localparam logic MODE_END    = 1'b1;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_PROMPT   = 8'h3E;
    localparam logic [7:0] CH_QUESTION = 8'h3F;

    localparam logic [7:0]   MARKER_SID    = 8'h62;
    localparam logic [55:0]  TXT_NO_DATA   = "NO DATA";
    localparam logic [55:0]  TXT_STOPPED   = "STOPPED";
    localparam logic [135:0] TXT_UNABLE    = "UNABLE TO CONNECT";
    localparam logic [39:0]  TXT_ERROR     = "ERROR";

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = (c <= 8'h39) ? (c - 8'h30) : (c - 8'h37);
        return v[3:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
               c == CH_FF || c == CH_VT;
    endfunction

endpackage

### design/did_response_text_parser.sv
// Parser for an adapter's text reply to a read-by-identifier request.
// The input channel carries one word per character (mode 0) or an end word
// (mode 1). The configuration channel writes the 16-bit identifier whose
// marker 62XXXX is searched; it is always ready.
// The output channel delivers data bytes (kind 0) decoded from digit pairs
// after the marker, and on every end word a final status word (kind 1):
// 0 ok, 1 no data or marker missing, 2 adapter error. Bytes are only
// meaningful when the following status is ok.
// Each accepted input word is processed in the cycle it is accepted; its
// results are written into the output queue in order. One input
// word is taken per cycle as long as the output queue has room for two
// results, which is set by the depth of the output queue.
// An end word can produce two results, so a stalled receiver fills the
// queue and input ready drops until words are taken again; nothing is lost.
// Reset clears the character window, the digit history, all line and
// response state, the output queue and the identifier (to zero).
module did_response_text_parser #(
    parameter int OUT_DEPTH = dtp_pkg::OUT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dtp_pkg::t_in  i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dtp_pkg::t_out o_out_word,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);
    import dtp_pkg::*;

    logic [15:0] r_id;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_pending, n_pending;
    logic        r_marker, n_marker;
    logic [3:0]  r_hi, n_hi;
    logic        r_have_hi, n_have_hi;
    logic        r_no_data, n_no_data;
    logic        r_error, n_error;
    logic [2:0]  r_cnt, n_cnt;

    logic [7:0]        w_win [WIN_LEN];
    logic [3:0]        w_hist [HIST_LEN];
    logic [3:0]        hist_ext [HIST_LEN + 2];
    logic [8*WIN_LEN-1:0] win_vec;
    t_cell_ctl         win_ctl, hist_ctl;

    logic       acc, is_end, line_end, c_hex;
    logic [7:0] c;
    logic [3:0] c_val;
    logic       push_a, push_b, have_f, have_s;
    logic [3:0] dig_f, dig_s;
    logic [2:0] cnt1, cnt2;
    logic       match1, match2;
    logic       emit_d, hshift, htwo;
    logic [7:0] dbyte;
    t_status    status;
    t_out       data_word, status_word, word0, word1;
    logic       push0, push1, room2;

    assign o_cfg_ready = 1'b1;
    assign acc         = i_in_valid & o_in_ready;
    assign o_in_ready  = room2;
    assign is_end      = (i_in_word.mode == MODE_END);
    assign c           = to_upper(i_in_word.character);
    assign c_hex       = is_hex(c);
    assign c_val       = hex_value(c);
    assign line_end    = (c == CH_CR) || (c == CH_LF) || (c == CH_PROMPT);

    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_vec[8*(WIN_LEN-1-i) +: 8] = w_win[i+1];
        end
        win_vec[7:0] = c;
    end

    genvar g;
    generate
        for (g = 0; g < WIN_LEN; g++) begin : g_win
            dtp_cell #(.WIDTH(8)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (win_ctl),
                .i_near ((g == WIN_LEN - 1) ? c : w_win[(g + 1) % WIN_LEN]),
                .i_far  (8'd0),
                .o_q    (w_win[g])
            );
        end
        for (g = 0; g < HIST_LEN; g++) begin : g_hist
            dtp_cell #(.WIDTH(4)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (hist_ctl),
                .i_near (hist_ext[g + 1]),
                .i_far  (hist_ext[g + 2]),
                .o_q    (w_hist[g])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < HIST_LEN; i++) begin
            hist_ext[i] = w_hist[i];
        end
        hist_ext[HIST_LEN]     = dig_f;
        hist_ext[HIST_LEN + 1] = dig_s;
    end

    assign cnt1   = (r_cnt == 3'(HIST_LEN)) ? r_cnt : r_cnt + 3'd1;
    assign cnt2   = (cnt1 == 3'(HIST_LEN)) ? cnt1 : cnt1 + 3'd1;
    assign match1 = (cnt1 == 3'(HIST_LEN)) &&
                    ({w_hist[1], w_hist[2], w_hist[3], w_hist[4], w_hist[5], dig_f} ==
                     {MARKER_SID, r_id});
    assign match2 = (cnt2 == 3'(HIST_LEN)) &&
                    ({w_hist[2], w_hist[3], w_hist[4], w_hist[5], dig_f, dig_s} ==
                     {MARKER_SID, r_id});

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_no_data = r_no_data;
        n_error   = r_error;
        push_a    = 1'b0;
        push_b    = 1'b0;
        if (is_end) begin
            push_a = (r_phase == PH_FIRST);
        end else begin
            if (win_vec[55:0] == TXT_NO_DATA || win_vec[55:0] == TXT_STOPPED ||
                win_vec == TXT_UNABLE) begin
                n_no_data = 1'b1;
            end
            if (win_vec[39:0] == TXT_ERROR || c == CH_QUESTION) begin
                n_error = 1'b1;
            end
            if (line_end) begin
                push_a    = (r_phase == PH_FIRST);
                n_phase   = PH_SKIP;
                n_pending = 4'd0;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if (is_space(c)) begin
                            n_phase = PH_SKIP;
                        end else if (c_hex) begin
                            n_pending = c_val;
                            n_phase   = PH_FIRST;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                    PH_FIRST: begin
                        n_phase   = PH_BODY;
                        n_pending = 4'd0;
                        if (c != CH_COLON) begin
                            push_a = 1'b1;
                            push_b = c_hex;
                        end
                    end
                    default: begin
                        push_b = c_hex;
                    end
                endcase
            end
        end
    end

    assign have_f = push_a | push_b;
    assign have_s = push_a & push_b;
    assign dig_f  = push_a ? r_pending : c_val;
    assign dig_s  = c_val;

    always_comb begin
        n_marker  = r_marker;
        n_have_hi = r_have_hi;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        emit_d    = 1'b0;
        dbyte     = 8'd0;
        hshift    = 1'b0;
        htwo      = 1'b0;
        if (have_f) begin
            if (n_marker) begin
                if (n_have_hi) begin
                    emit_d    = 1'b1;
                    dbyte     = {n_hi, dig_f};
                    n_have_hi = 1'b0;
                    n_hi      = 4'd0;
                end else begin
                    n_hi      = dig_f;
                    n_have_hi = 1'b1;
                end
            end else begin
                hshift   = 1'b1;
                n_cnt    = cnt1;
                n_marker = match1;
            end
        end
        if (have_s) begin
            if (n_marker) begin
                if (n_have_hi) begin
                    emit_d    = 1'b1;
                    dbyte     = {n_hi, dig_s};
                    n_have_hi = 1'b0;
                    n_hi      = 4'd0;
                end else begin
                    n_hi      = dig_s;
                    n_have_hi = 1'b1;
                end
            end else begin
                htwo     = 1'b1;
                n_cnt    = cnt2;
                n_marker = match2;
            end
        end
    end

    always_comb begin
        priority if (r_no_data) begin
            status = ST_NO_DATA;
        end else if (r_error) begin
            status = ST_ADAPTER_ERR;
        end else if (!n_marker) begin
            status = ST_NO_DATA;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        data_word   = '{kind: KIND_DATA, data_byte: dbyte, status: ST_OK};
        status_word = '{kind: KIND_STATUS, data_byte: 8'd0, status: status};
        word0       = emit_d ? data_word : status_word;
        word1       = status_word;
        push0       = acc & (emit_d | is_end);
        push1       = acc & emit_d & is_end;
    end

    always_comb begin
        win_ctl  = '{shift: acc & ~is_end, two: 1'b0, clr: acc & is_end};
        hist_ctl = '{shift: acc & hshift, two: htwo, clr: acc & is_end};
    end

    dtp_out_fifo #(.DEPTH(OUT_DEPTH)) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push0(push0),
        .i_push1(push1),
        .i_word0(word0),
        .i_word1(word1),
        .o_room2(room2),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_word (o_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_pending <= 4'd0;
            r_marker  <= 1'b0;
            r_hi      <= 4'd0;
            r_have_hi <= 1'b0;
            r_no_data <= 1'b0;
            r_error   <= 1'b0;
            r_cnt     <= 3'd0;
        end else if (acc) begin
            if (is_end) begin
                r_phase   <= PH_SKIP;
                r_pending <= 4'd0;
                r_marker  <= 1'b0;
                r_hi      <= 4'd0;
                r_have_hi <= 1'b0;
                r_no_data <= 1'b0;
                r_error   <= 1'b0;
                r_cnt     <= 3'd0;
            end else begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_marker  <= n_marker;
                r_hi      <= n_hi;
                r_have_hi <= n_have_hi;
                r_no_data <= n_no_data;
                r_error   <= n_error;
                r_cnt     <= n_cnt;
            end
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_end) |=> (!r_marker && !r_have_hi && r_cnt == 3'd0))
        else $error("response state not cleared after end word");

    a_nibble_after_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_hi |-> r_marker)
        else $error("half byte held before marker found");

    a_pending_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_FIRST) |-> (r_pending == 4'd0))
        else $error("held digit outside first-digit phase");

endmodule

### design/dtp_cell.sv
module dtp_cell #(
    parameter int WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtp_pkg::t_cell_ctl     i_ctl,
    input  logic [WIDTH-1:0]       i_near,
    input  logic [WIDTH-1:0]       i_far,
    output logic [WIDTH-1:0]       o_q
);
    import dtp_pkg::*;

    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.clr) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_ctl.two ? i_far : i_near;
        end
    end

    assign o_q = r_q;

endmodule

### design/dtp_out_fifo.sv
module dtp_out_fifo #(
    parameter int DEPTH = dtp_pkg::OUT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push0,
    input  logic          i_push1,
    input  dtp_pkg::t_out i_word0,
    input  dtp_pkg::t_out i_word1,
    output logic          o_room2,
    output logic          o_valid,
    input  logic          i_ready,
    output dtp_pkg::t_out o_word
);
    import dtp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_out          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic [PW-1:0] wr1;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign wr1     = ptr_inc(r_wr);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push0) + CW'(i_push1) - CW'(pop);
        if (i_push1) begin
            n_wr = ptr_inc(wr1);
        end else if (i_push0) begin
            n_wr = wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_word0;
        end
        if (i_push1) begin
            r_mem[wr1] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("output queue count beyond depth");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second slot written without first");

endmodule

### tb/did_response_text_parser_tb.sv
`timescale 1ns / 1ps

module did_response_text_parser_tb;
    import dtp_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int SQUEEZE_AT   = 150;
    localparam int SQUEEZE_LEN  = 250;
    localparam int PHASE_ITEMS  = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    did_response_text_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in  tx_words[$];
    t_out due_words[$];
    t_out want;
    int   words_queued = 0;
    int   words_taken = 0;
    int   faults = 0;
    int   send_gap = 0;
    int   send_calm = 0;
    int   recv_hold = 0;
    int   recv_calm = 0;
    bit   squeezed = 1'b0;
    int   idle_cycles = 0;

    // Parser state as seen by the checker.
    logic [15:0]  ident_cfg = '0;
    logic [135:0] seen_text;
    logic [23:0]  digit_trail;
    int           digit_count;
    t_phase       line_state;
    logic [3:0]   held_digit;
    logic [3:0]   hi_nib;
    bit           hi_valid;
    bit           marker_hit;
    bit           nodata_flag;
    bit           error_flag;

    function automatic bit hexish(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nib_of(input logic [7:0] c);
        if (c <= "9") begin
            return 4'(c - "0");
        end
        return 4'(c - "A" + 10);
    endfunction

    function automatic void clear_response();
        seen_text   = '0;
        digit_trail = '0;
        digit_count = 0;
        line_state  = PH_SKIP;
        held_digit  = '0;
        hi_nib      = '0;
        hi_valid    = 1'b0;
        marker_hit  = 1'b0;
        nodata_flag = 1'b0;
        error_flag  = 1'b0;
    endfunction

    function automatic void feed_digit(input logic [3:0] d);
        if (marker_hit) begin
            if (hi_valid) begin
                due_words.push_back(t_out'{kind: KIND_DATA, data_byte: {hi_nib, d},
                                           status: ST_OK});
                hi_valid = 1'b0;
                hi_nib = '0;
            end else begin
                hi_nib = d;
                hi_valid = 1'b1;
            end
            return;
        end
        digit_trail = {digit_trail[19:0], d};
        if (digit_count < 6) begin
            digit_count++;
        end
        if (digit_count == 6 && digit_trail == {MARKER_SID, ident_cfg}) begin
            marker_hit = 1'b1;
        end
    endfunction

    function automatic void absorb_word(input t_in w);
        logic [7:0] c;
        t_status    st;
        if (w.mode == MODE_END) begin
            if (line_state == PH_FIRST) begin
                feed_digit(held_digit);
            end
            if (nodata_flag) begin
                st = ST_NO_DATA;
            end else if (error_flag) begin
                st = ST_ADAPTER_ERR;
            end else if (!marker_hit) begin
                st = ST_NO_DATA;
            end else begin
                st = ST_OK;
            end
            due_words.push_back(t_out'{kind: KIND_STATUS, data_byte: 8'h00, status: st});
            clear_response();
            return;
        end
        c = w.character;
        if (c >= "a" && c <= "z") begin
            c = c - 8'h20;
        end
        seen_text = {seen_text[127:0], c};
        if (seen_text[55:0] == TXT_NO_DATA || seen_text[55:0] == TXT_STOPPED ||
            seen_text == TXT_UNABLE) begin
            nodata_flag = 1'b1;
        end
        if (seen_text[39:0] == TXT_ERROR || c == CH_QUESTION) begin
            error_flag = 1'b1;
        end
        if (c == CH_CR || c == CH_LF || c == CH_PROMPT) begin
            if (line_state == PH_FIRST) begin
                feed_digit(held_digit);
            end
            line_state = PH_SKIP;
            held_digit = '0;
            return;
        end
        case (line_state)
            PH_SKIP: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT) begin
                    return;
                end
                if (hexish(c)) begin
                    held_digit = nib_of(c);
                    line_state = PH_FIRST;
                end else begin
                    line_state = PH_BODY;
                end
                return;
            end
            PH_FIRST: begin
                line_state = PH_BODY;
                if (c == CH_COLON) begin
                    held_digit = '0;
                    return;
                end
                feed_digit(held_digit);
                held_digit = '0;
            end
            default: ;
        endcase
        if (hexish(c)) begin
            feed_digit(nib_of(c));
        end
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                absorb_word(i_in_word);
                words_taken++;
            end
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (tx_words.size() != 0) begin
                i_in_word <= tx_words.pop_front();
                i_in_valid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $error("unexpected word: kind %0d, data_byte %02h, status %0d",
                           o_out_word.kind, o_out_word.data_byte, o_out_word.status);
                    faults++;
                end else begin
                    want = due_words.pop_front();
                    if (o_out_word.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, o_out_word.kind);
                        faults++;
                    end
                    if (o_out_word.data_byte !== want.data_byte) begin
                        $error("data_byte: expected %02h, actual %02h",
                               want.data_byte, o_out_word.data_byte);
                        faults++;
                    end
                    if (o_out_word.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_word.status);
                        faults++;
                    end
                end
            end
            // A long stall once traffic is running fills the block and blocks its input.
            if (!squeezed && words_taken >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                recv_hold = SQUEEZE_LEN;
            end
            if (recv_hold != 0) begin
                recv_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_hold = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic put_char(input logic [7:0] c);
        tx_words.push_back(t_in'{mode: MODE_CHAR, character: c});
        words_queued++;
    endtask

    task automatic put_end();
        tx_words.push_back(t_in'{mode: MODE_END, character: 8'($urandom)});
        words_queued++;
    endtask

    task automatic put_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
                c = c | 8'h20;
            end
            put_char(c);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 10) begin
            c = 8'h30 + 8'(n);
        end else begin
            c = 8'h41 + 8'(n) - 8'd10;
            if ($urandom_range(0, 1) == 1) begin
                c = c | 8'h20;
            end
        end
        return c;
    endfunction

    task automatic put_blank();
        case ($urandom_range(0, 3))
            0: put_char(CH_SPACE);
            1: put_char(CH_TAB);
            2: put_char(CH_FF);
            default: put_char(CH_VT);
        endcase
    endtask

    task automatic put_line_end();
        case ($urandom_range(0, 3))
            0: put_char(CH_CR);
            1: put_char(CH_LF);
            2: begin
                put_char(CH_CR);
                put_char(CH_LF);
            end
            default: put_char(CH_PROMPT);
        endcase
    endtask

    task automatic put_data_line(input logic [15:0] id);
        logic [23:0] mk;
        int          r;
        int          pos;
        repeat ($urandom_range(0, 2)) put_blank();
        if ($urandom_range(0, 2) == 0) begin
            put_char(hex_char(4'($urandom_range(0, 15))));
            put_char(CH_COLON);
        end
        repeat ($urandom_range(0, 3)) put_char(hex_char(4'($urandom_range(0, 15))));
        mk = {MARKER_SID, id};
        r = $urandom_range(0, 9);
        if (r >= 7 && r <= 8) begin
            pos = $urandom_range(0, 5);
            mk[pos*4 +: 4] = mk[pos*4 +: 4] ^ 4'($urandom_range(1, 15));
        end
        if (r != 9) begin
            for (int i = 5; i >= 0; i--) begin
                put_char(hex_char(mk[i*4 +: 4]));
                if ($urandom_range(0, 3) == 0) put_char(CH_SPACE);
            end
        end
        repeat ($urandom_range(0, 12)) begin
            put_char(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 2) == 0) put_char(CH_SPACE);
        end
    endtask

    task automatic put_response(input logic [15:0] id);
        int r;
        int lines;
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                put_data_line(id);
            end else if (r < 76) begin
                case ($urandom_range(0, 4))
                    0: put_text("NO DATA", 1'b1);
                    1: put_text("STOPPED", 1'b1);
                    2: put_text("UNABLE TO CONNECT", 1'b1);
                    3: put_text("ERROR", 1'b1);
                    default: put_char(CH_QUESTION);
                endcase
            end else begin
                repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
            end
            if (l != lines - 1 || $urandom_range(0, 3) != 0) begin
                put_line_end();
            end
        end
        put_end();
    endtask

    task automatic run_responses(input int count);
        int stop_at;
        stop_at = words_queued + count;
        while (words_queued < stop_at) begin
            put_response(ident_cfg);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (words_taken != words_queued || due_words.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_ident(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ident_cfg = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        clear_response();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The identifier is still at its reset value of zero here.
        put_end();
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_QUESTION);
        put_end();
        put_text("a:62000000fF", 1'b0);
        put_char(CH_CR);
        put_text("1", 1'b0);
        put_end();
        wait_drained();

        write_ident(16'hFFFF);
        run_responses(PHASE_ITEMS);
        wait_drained();

        write_ident(16'($urandom));
        run_responses(PHASE_ITEMS);
        wait_drained();

        write_ident(16'hF190);
        run_responses(PHASE_ITEMS);
        wait_drained();

        write_ident(16'h0000);
        run_responses(PHASE_ITEMS);
        wait_drained();

        if (faults == 0 && due_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/dtp_pkg.sv
design/dtp_cell.sv
design/dtp_out_fifo.sv
design/did_response_text_parser.sv
tb/did_response_text_parser_tb.sv
